FILE: src/pew_pkg.sv
// shared types, constants and helpers for the prewitt rgb edge block
`default_nettype none

package pew_pkg;

  localparam int MAX_LINE_PIXELS = 1024;
  localparam int MAX_FRAME_ROWS  = 1024;

  localparam int COL_W  = $clog2(MAX_LINE_PIXELS);
  localparam int ROW_W  = $clog2(MAX_FRAME_ROWS);
  localparam int DIM_W  = 11;
  localparam int CHAN_W = 8;
  localparam int PIX_W  = 3 * CHAN_W;
  localparam int LS_W   = 2 * PIX_W;

  localparam int SUM_W        = 10;
  localparam int PROD_W       = 19;
  localparam int EDGE_SCALE   = 483;
  localparam int SCALE_SHIFT  = 10;
  localparam int MAG_MAX      = 255;

  localparam logic [DIM_W-1:0] DIM_MIN          = 11'd3;
  localparam logic [DIM_W-1:0] WIDTH_AT_RESET   = 11'd640;
  localparam logic [DIM_W-1:0] HEIGHT_AT_RESET  = 11'd480;

  // configuration register indexes
  typedef enum logic {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_t;

  // input word kinds
  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  // one window column, top row first
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } column_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              frame_end;
  } result_t;

  // clamp a written frame dimension into [3, hi]
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int hi);
    logic [DIM_W-1:0] res;
    if (v < DIM_MIN) begin
      res = DIM_MIN;
    end else if (int'(v) > hi) begin
      res = DIM_W'(hi);
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: src/pew_line_store.sv
// line store memory: upper and middle line pixels packed in one entry per column
`default_nettype none

module pew_line_store
  import pew_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [COL_W-1:0] rd_addr,
  output logic      [LS_W-1:0]  rd_data_r,
  input  wire logic             wr_en,
  input  wire logic [COL_W-1:0] wr_addr,
  input  wire logic [LS_W-1:0]  wr_data
);

  logic [LS_W-1:0] mem [MAX_LINE_PIXELS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: src/pew_col_cell.sv
// one column cell of the 3x3 window, loads from its right-hand neighbor
`default_nettype none

module pew_col_cell
  import pew_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    shift_en,
  input  wire column_t col_in,
  output column_t      col_r
);

  column_t col_nxt;

  always_comb begin
    col_nxt = shift_en ? col_in : col_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else begin
      col_r <= col_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/pew_edge_calc.sv
// one color channel: registered column difference, then scaled and saturated magnitude
`default_nettype none

module pew_edge_calc
  import pew_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  load,
  input  wire logic [2:0][CHAN_W-1:0] left,
  input  wire logic [2:0][CHAN_W-1:0] right,
  output logic      [CHAN_W-1:0]     mag
);

  logic [SUM_W-1:0]  left_sum;
  logic [SUM_W-1:0]  right_sum;
  logic [SUM_W-1:0]  abs_nxt;
  logic [SUM_W-1:0]  abs_r;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] scaled;

  always_comb begin
    left_sum  = SUM_W'(left[0]) + SUM_W'(left[1]) + SUM_W'(left[2]);
    right_sum = SUM_W'(right[0]) + SUM_W'(right[1]) + SUM_W'(right[2]);
    abs_nxt   = (right_sum >= left_sum) ? (right_sum - left_sum) : (left_sum - right_sum);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      abs_r <= abs_nxt;
    end
  end

  // |s| * 483 >> 10, saturated
  always_comb begin
    prod   = PROD_W'(abs_r) * PROD_W'(EDGE_SCALE);
    scaled = prod >> SCALE_SHIFT;
    mag    = (scaled > PROD_W'(MAG_MAX)) ? CHAN_W'(MAG_MAX) : scaled[CHAN_W-1:0];
  end

endmodule

`default_nettype wire

FILE: src/prewitt_edge_rgb_3x3.sv
// top level of the streaming 3x3 prewitt edge detector on rgb pixels
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------------
//  in      | in        | in_valid/in_stall   | in_op, in_red_in, in_green_in, in_blue_in
//  out     | out       | out_valid/out_stall | out_red_edge, out_green_edge,
//          |           |                     | out_blue_edge, out_frame_end
//  cfg     | in        | cfg_wr_en           | cfg_index, cfg_data
//
// one word per clock sustained while in_stall is low; an accepted word passes the line store
// read and stage 1 registers, the window column cells, the registered column difference,
// then scale and clamp into the output register
// the line store is one 1024 x 48 memory, one read and one write per cycle
// reset is synchronous; the line store has no clearing pass, and entries the frame has
// not yet written are read but reach only border windows, which give zero
// in_stall rises only when the skid stage behind the output register is full
`default_nettype none

module prewitt_edge_rgb_3x3
  import pew_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input words
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_op,
  input  wire logic [CHAN_W-1:0] in_red_in,
  input  wire logic [CHAN_W-1:0] in_green_in,
  input  wire logic [CHAN_W-1:0] in_blue_in,
  // result words
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [CHAN_W-1:0] out_red_edge,
  output logic      [CHAN_W-1:0] out_green_edge,
  output logic      [CHAN_W-1:0] out_blue_edge,
  output logic                   out_frame_end,
  // configuration writes
  input  wire logic              cfg_wr_en,
  input  wire logic              cfg_index,
  input  wire logic [DIM_W-1:0]  cfg_data
);

  // ---------------------------------------------------------------------------
  // configuration, stored already clamped
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0] width_r, width_nxt;
  logic [DIM_W-1:0] height_r, height_nxt;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FRAME_WIDTH:  width_nxt  = clamp_dim(cfg_data, MAX_LINE_PIXELS);
        CFG_FRAME_HEIGHT: height_nxt = clamp_dim(cfg_data, MAX_FRAME_ROWS);
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_AT_RESET;
      height_r <= HEIGHT_AT_RESET;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // handshake and pipeline enable
  // ---------------------------------------------------------------------------
  logic skid_valid_r;
  logic pipe_en;
  logic in_accept;
  logic pix_take;
  logic flush_take;

  assign pipe_en    = !skid_valid_r;
  assign in_stall   = skid_valid_r;
  assign in_accept  = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // frame position counters
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [DIM_W-1:0] flush_cnt_r, flush_cnt_nxt;
  logic             draining_r, draining_nxt;
  logic             col_last;
  logic             row_last;
  logic             flush_last;
  logic             emit_now;
  logic             inner_now;

  assign pix_take   = in_accept && (op_t'(in_op) == OP_PIXEL) && !draining_r;
  assign flush_take = in_accept && (op_t'(in_op) == OP_FLUSH) && draining_r;

  assign col_last   = (DIM_W'(col_r) == (width_r - DIM_W'(1)));
  assign row_last   = (DIM_W'(row_r) == (height_r - DIM_W'(1)));
  // last of the width + 1 flush words owed after the final pixel
  assign flush_last = (flush_cnt_r == width_r);

  // a pixel emits once it is a line and a pixel past the frame start
  assign emit_now  = (row_r >= ROW_W'(2)) || ((row_r == ROW_W'(1)) && (col_r >= COL_W'(1)));
  // the emitted window is off the border only from row 2, column 2 on
  assign inner_now = (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2));

  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    flush_cnt_nxt = flush_cnt_r;
    draining_nxt  = draining_r;
    priority if (cfg_wr_en) begin
      // any register write restarts the frame
      col_nxt       = '0;
      row_nxt       = '0;
      flush_cnt_nxt = '0;
      draining_nxt  = 1'b0;
    end else if (pix_take) begin
      if (col_last) begin
        col_nxt = '0;
        if (row_last) begin
          row_nxt      = '0;
          draining_nxt = 1'b1;
        end else begin
          row_nxt = row_r + ROW_W'(1);
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end else if (flush_take) begin
      if (flush_last) begin
        flush_cnt_nxt = '0;
        draining_nxt  = 1'b0;
      end else begin
        flush_cnt_nxt = flush_cnt_r + DIM_W'(1);
      end
    end else begin
      // idle cycle, position held
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      flush_cnt_r <= '0;
      draining_r  <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      flush_cnt_r <= flush_cnt_nxt;
      draining_r  <= draining_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: line store read in flight, incoming pixel held
  // ---------------------------------------------------------------------------
  logic             s1_pix_r;
  logic             s1_out_r;
  logic             s1_inner_r;
  logic             s1_fe_r;
  logic [PIX_W-1:0] s1_px_r;
  logic [COL_W-1:0] s1_addr_r;
  logic [LS_W-1:0]  ls_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_pix_r <= 1'b0;
      s1_out_r <= 1'b0;
    end else if (pipe_en) begin
      s1_pix_r <= pix_take;
      s1_out_r <= (pix_take && emit_now) || flush_take;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_inner_r <= pix_take && inner_now;
      s1_fe_r    <= flush_take && flush_last;
    end
    if (pix_take) begin
      s1_px_r   <= {in_red_in, in_green_in, in_blue_in};
      s1_addr_r <= col_r;
    end
  end

  // upper line entry takes the old middle, middle takes the new pixel
  pew_line_store u_line_store (
    .clk       (clk),
    .rd_en     (pix_take),
    .rd_addr   (col_r),
    .rd_data_r (ls_rd_data),
    .wr_en     (pipe_en && s1_pix_r),
    .wr_addr   (s1_addr_r),
    .wr_data   ({ls_rd_data[PIX_W-1:0], s1_px_r})
  );

  // ---------------------------------------------------------------------------
  // stage 2: window column cells, right to left
  // ---------------------------------------------------------------------------
  logic    shift_en;
  column_t new_col;
  column_t col2;
  column_t col1;
  column_t col0;

  assign shift_en = pipe_en && s1_pix_r;
  assign new_col  = '{top: ls_rd_data[LS_W-1:PIX_W], mid: ls_rd_data[PIX_W-1:0], bot: s1_px_r};

  pew_col_cell u_cell_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (shift_en),
    .col_in   (new_col),
    .col_r    (col2)
  );

  pew_col_cell u_cell_center (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (shift_en),
    .col_in   (col2),
    .col_r    (col1)
  );

  pew_col_cell u_cell_left (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (shift_en),
    .col_in   (col1),
    .col_r    (col0)
  );

  logic s2_out_r;
  logic s2_inner_r;
  logic s2_fe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_out_r <= 1'b0;
    end else if (pipe_en) begin
      s2_out_r <= s1_out_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s2_inner_r <= s1_inner_r;
      s2_fe_r    <= s1_fe_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: per channel column difference registered, scale at the output
  // ---------------------------------------------------------------------------
  logic [CHAN_W-1:0] red_mag;
  logic [CHAN_W-1:0] green_mag;
  logic [CHAN_W-1:0] blue_mag;

  // red sits in the high byte of each pixel, blue in the low byte
  pew_edge_calc u_edge_red (
    .clk   (clk),
    .load  (pipe_en),
    .left  ({col0.bot[23:16], col0.mid[23:16], col0.top[23:16]}),
    .right ({col2.bot[23:16], col2.mid[23:16], col2.top[23:16]}),
    .mag   (red_mag)
  );

  pew_edge_calc u_edge_green (
    .clk   (clk),
    .load  (pipe_en),
    .left  ({col0.bot[15:8], col0.mid[15:8], col0.top[15:8]}),
    .right ({col2.bot[15:8], col2.mid[15:8], col2.top[15:8]}),
    .mag   (green_mag)
  );

  pew_edge_calc u_edge_blue (
    .clk   (clk),
    .load  (pipe_en),
    .left  ({col0.bot[7:0], col0.mid[7:0], col0.top[7:0]}),
    .right ({col2.bot[7:0], col2.mid[7:0], col2.top[7:0]}),
    .mag   (blue_mag)
  );

  logic s3_out_r;
  logic s3_inner_r;
  logic s3_fe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_out_r <= 1'b0;
    end else if (pipe_en) begin
      s3_out_r <= s2_out_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s3_inner_r <= s2_inner_r;
      s3_fe_r    <= s2_fe_r;
    end
  end

  // border windows and flush words give zero
  result_t push_word;
  logic    push;

  assign push = pipe_en && s3_out_r;

  always_comb begin
    push_word.red       = s3_inner_r ? red_mag   : '0;
    push_word.green     = s3_inner_r ? green_mag : '0;
    push_word.blue      = s3_inner_r ? blue_mag  : '0;
    push_word.frame_end = s3_fe_r;
  end

  // ---------------------------------------------------------------------------
  // output register with one skid stage behind it
  // ---------------------------------------------------------------------------
  result_t out_word_r;
  result_t skid_word_r;
  logic    out_valid_r;
  logic    out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_word_r <= skid_word_r;
      end else if (push) begin
        out_word_r <= push_word;
      end
    end else if (push) begin
      skid_word_r <= push_word;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red_edge   = out_word_r.red;
  assign out_green_edge = out_word_r.green;
  assign out_blue_edge  = out_word_r.blue;
  assign out_frame_end  = out_word_r.frame_end;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
`ifndef SYNTHESIS
  // the skid stage only fills behind a held output word
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage full with no output word");

  // a held skid word stays while the output is stalled
  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_stall) |=> skid_valid_r)
    else $error("skid word lost under stall");

  // frame end word is a border word, always zero
  a_frame_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.frame_end) |->
      (out_word_r.red == '0 && out_word_r.green == '0 && out_word_r.blue == '0))
    else $error("frame end word carries an edge value");

  // while draining the position sits at the frame start
  a_drain_position: assert property (@(posedge clk) disable iff (!rst_n)
    draining_r |-> (col_r == '0 && row_r == '0))
    else $error("position moved while draining");
`endif

endmodule

`default_nettype wire

FILE: dv/prewitt_edge_rgb_3x3_tb.sv
// testbench for the prewitt rgb edge block: random pixel frames checked against a predictor
`timescale 1ns / 1ps

module prewitt_edge_rgb_3x3_tb;
  import pew_pkg::*;

  localparam int RANDOM_WORDS  = 520;        // useful words in the random part
  localparam int WIDE_PIXELS   = 100;        // start of a frame on the widest line
  localparam int SETTLE_CYCLES = 10;         // pipeline depth plus skid, before a register write
  localparam int TAIL_CYCLES   = 20;         // watch for stray words at the end
  localparam longint CYCLE_LIMIT = 5_000_000;

  // predictor of the edge stream plus the queue of edge words still owed by the block
  class edge_tracker;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [PIX_W-1:0] upper_line  [MAX_LINE_PIXELS];
    logic [PIX_W-1:0] middle_line [MAX_LINE_PIXELS];
    logic [PIX_W-1:0] win [3][3];
    int col_pos;
    int row_pos;
    int emitted;
    bit draining;
    result_t owed_edges[$];
    int mismatches;
    int words_seen;

    function new();
      width_reg  = WIDTH_AT_RESET;
      height_reg = HEIGHT_AT_RESET;
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      restart_frame();
      mismatches = 0;
      words_seen = 0;
    endfunction

    function void restart_frame();
      col_pos  = 0;
      row_pos  = 0;
      emitted  = 0;
      draining = 1'b0;
    endfunction

    function int fit_dim(logic [DIM_W-1:0] v, int hi);
      if (v < 3) return 3;
      if (int'(v) > hi) return hi;
      return int'(v);
    endfunction

    function int eff_w();
      return fit_dim(width_reg, MAX_LINE_PIXELS);
    endfunction

    function int eff_h();
      return fit_dim(height_reg, MAX_FRAME_ROWS);
    endfunction

    function void write_reg(cfg_idx_t idx, logic [DIM_W-1:0] v);
      case (idx)
        CFG_FRAME_WIDTH:  width_reg = v;
        CFG_FRAME_HEIGHT: height_reg = v;
        default: ;
      endcase
      restart_frame();
    endfunction

    // right column minus left column for one channel, scaled and clamped
    function logic [CHAN_W-1:0] scaled_gradient(int sh);
      int right;
      int left;
      int mag;
      right = int'(win[0][2][sh +: CHAN_W]) + int'(win[1][2][sh +: CHAN_W])
            + int'(win[2][2][sh +: CHAN_W]);
      left  = int'(win[0][0][sh +: CHAN_W]) + int'(win[1][0][sh +: CHAN_W])
            + int'(win[2][0][sh +: CHAN_W]);
      mag = (((right >= left) ? right - left : left - right) * EDGE_SCALE) >> SCALE_SHIFT;
      return (mag > MAG_MAX) ? CHAN_W'(MAG_MAX) : CHAN_W'(mag);
    endfunction

    // notes one accepted input word; returns 1 when the word did any work
    function bit take_word(op_t op, logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                           logic [CHAN_W-1:0] b);
      int w;
      int h;
      int c;
      int rr;
      logic [PIX_W-1:0] px;
      result_t res;
      w = eff_w();
      h = eff_h();
      res = '0;
      if (op == OP_FLUSH) begin
        if (!draining) return 1'b0;
        emitted++;
        if (emitted >= w * h) begin
          res.frame_end = 1'b1;
          restart_frame();
        end
        owed_edges.push_back(res);
        return 1'b1;
      end
      if (draining) return 1'b0;
      if (col_pos >= w) col_pos = 0;
      if (row_pos >= h) row_pos = 0;
      c  = col_pos;
      rr = row_pos;
      px = {r, g, b};
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = upper_line[c];
      win[1][2] = middle_line[c];
      win[2][2] = px;
      upper_line[c]  = middle_line[c];
      middle_line[c] = px;
      if (rr >= 2 || (rr == 1 && c >= 1)) begin
        if (rr >= 2 && c >= 2) begin
          res.red   = scaled_gradient(2 * CHAN_W);
          res.green = scaled_gradient(CHAN_W);
          res.blue  = scaled_gradient(0);
        end
        emitted++;
        owed_edges.push_back(res);
      end
      col_pos = c + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos = rr + 1;
        if (row_pos >= h) begin
          row_pos  = 0;
          draining = 1'b1;
        end
      end
      return 1'b1;
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    task match_edge_word(result_t got);
      result_t want;
      words_seen++;
      if (owed_edges.size() == 0) begin
        report_mismatch($sformatf("edge word %0d arrived with none owed", words_seen));
        return;
      end
      want = owed_edges.pop_front();
      if (got.red !== want.red)
        report_mismatch($sformatf("word %0d red_edge %0d, want %0d",
                                  words_seen, got.red, want.red));
      if (got.green !== want.green)
        report_mismatch($sformatf("word %0d green_edge %0d, want %0d",
                                  words_seen, got.green, want.green));
      if (got.blue !== want.blue)
        report_mismatch($sformatf("word %0d blue_edge %0d, want %0d",
                                  words_seen, got.blue, want.blue));
      if (got.frame_end !== want.frame_end)
        report_mismatch($sformatf("word %0d frame_end %0b, want %0b",
                                  words_seen, got.frame_end, want.frame_end));
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  op_t               in_op;
  logic [CHAN_W-1:0] in_red;
  logic [CHAN_W-1:0] in_green;
  logic [CHAN_W-1:0] in_blue;
  logic              out_valid;
  logic              out_stall;
  logic [CHAN_W-1:0] out_red_edge;
  logic [CHAN_W-1:0] out_green_edge;
  logic [CHAN_W-1:0] out_blue_edge;
  logic              out_frame_end;
  logic              cfg_wr_en;
  cfg_idx_t          cfg_index;
  logic [DIM_W-1:0]  cfg_data;

  edge_tracker tracker = new();
  bit          calm;          // phase with no gaps and no stalls
  int unsigned fed_words;     // input words that did work
  longint      cycle_count;

  prewitt_edge_rgb_3x3 dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_red_in      (in_red),
    .in_green_in    (in_green),
    .in_blue_in     (in_blue),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red_edge   (out_red_edge),
    .out_green_edge (out_green_edge),
    .out_blue_edge  (out_blue_edge),
    .out_frame_end  (out_frame_end),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // runaway guard
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[prewitt_edge_rgb_3x3] ERROR");
      $finish;
    end
  end

  // run length of a gap or a stall: mostly short, a few long
  function automatic int pick_run();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_gap();
    if (calm) return 0;
    if ($urandom_range(0, 99) < 55) return 0;
    return pick_run();
  endfunction

  // channel level; stark frames use only black and white to force saturation
  function automatic logic [CHAN_W-1:0] pick_level(bit stark);
    int r;
    if (stark) return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'h00;
    if (r < 20) return 8'hff;
    return CHAN_W'($urandom_range(0, 255));
  endfunction

  // raw register values, some below the clamp floor
  function automatic logic [DIM_W-1:0] pick_width();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return DIM_W'($urandom_range(0, 2));
    if (r < 75) return DIM_W'($urandom_range(3, 8));
    if (r < 95) return DIM_W'($urandom_range(9, 24));
    return DIM_W'($urandom_range(25, 40));
  endfunction

  function automatic logic [DIM_W-1:0] pick_height();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return DIM_W'($urandom_range(0, 2));
    if (r < 85) return DIM_W'($urandom_range(3, 6));
    return DIM_W'($urandom_range(7, 10));
  endfunction

  // result side: random stall runs driven on the falling edge
  initial begin
    int hold;
    out_stall = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (calm) begin
        out_stall = 1'b0;
        hold = 0;
      end else if (hold > 0) begin
        hold--;
      end else if (out_stall) begin
        out_stall = 1'b0;
        // free stretches, now and then a long one
        hold = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 8) : $urandom_range(20, 80);
      end else begin
        out_stall = 1'b1;
        hold = pick_run() - 1;
      end
    end
  end

  // result side: a word moves on a rising edge with valid high and stall low
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.match_edge_word({out_red_edge, out_green_edge, out_blue_edge, out_frame_end});
  end

  // one input word; entered and left at a falling edge, valid stays high for the next word
  task automatic send_word(op_t op, logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                           logic [CHAN_W-1:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_op    = op;
    in_red   = r;
    in_green = g;
    in_blue  = b;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    if (tracker.take_word(op, r, g, b)) fed_words++;
    @(negedge clk);
  endtask

  task automatic send_pixel(bit stark);
    send_word(OP_PIXEL, pick_level(stark), pick_level(stark), pick_level(stark));
  endtask

  // colour fields of a flush are don't-care, so they get noise
  task automatic send_flush();
    send_word(OP_FLUSH, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [DIM_W-1:0] v);
    cfg_index = idx;
    cfg_data  = v;
    cfg_wr_en = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    tracker.write_reg(idx, v);
  endtask

  // drain everything owed, then let words with no result clear the pipeline
  task automatic settle();
    in_valid = 1'b0;
    while (tracker.owed_edges.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // one frame: pixels then the flushes that push out the owed border words;
  // when allowed, it may stop part way through the pixels or the flushes
  task automatic run_frame(bit may_cut);
    int w;
    int h;
    int total;
    int npix;
    int nflush;
    int mode;
    bit stark;
    w = tracker.eff_w();
    h = tracker.eff_h();
    total = w * h;
    stark = ($urandom_range(0, 4) == 0);
    mode = may_cut ? $urandom_range(0, 5) : 0;
    npix = (mode == 4) ? $urandom_range(1, total - 1) : total;
    for (int i = 0; i < npix; i++) begin
      // stray flush mid frame, ignored by the block
      if ($urandom_range(0, 99) < 4) send_flush();
      send_pixel(stark);
    end
    if (mode == 4) return;
    nflush = (mode == 5) ? $urandom_range(0, w) : w + 1;
    for (int i = 0; i < nflush; i++) begin
      // stray pixel while draining, dropped by the block
      if ($urandom_range(0, 99) < 4) send_pixel(stark);
      send_flush();
    end
  endtask

  // new geometry, then one to three frames; only the last may be cut short
  task automatic run_phase();
    int nframes;
    calm = ($urandom_range(0, 3) == 0);
    settle();
    case ($urandom_range(0, 2))
      0: write_reg(CFG_FRAME_WIDTH, pick_width());
      1: write_reg(CFG_FRAME_HEIGHT, pick_height());
      default: begin
        write_reg(CFG_FRAME_WIDTH, pick_width());
        write_reg(CFG_FRAME_HEIGHT, pick_height());
      end
    endcase
    nframes = $urandom_range(1, 3);
    for (int k = 0; k < nframes; k++) run_frame(k == nframes - 1);
  endtask

  initial begin
    in_valid  = 1'b0;
    in_op     = OP_PIXEL;
    in_red    = '0;
    in_green  = '0;
    in_blue   = '0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_FRAME_WIDTH;
    cfg_data  = '0;
    calm      = 1'b0;
    fed_words = 0;
    rst_n     = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: smallest frame, both registers below the floor so they clamp to 3
    write_reg(CFG_FRAME_WIDTH, 11'd0);
    write_reg(CFG_FRAME_HEIGHT, 11'd2);
    // flush before the frame is in, ignored
    send_flush();
    // left column red 0 / green 255, right column red 255 / green 0: both saturate;
    // blue climbs from 10..30 on the left to 40..60 on the right for a mid value
    for (int row = 0; row < 3; row++) begin
      send_word(OP_PIXEL, 8'h00, 8'hff, CHAN_W'(10 * (row + 1)));
      send_word(OP_PIXEL, 8'h5a, 8'ha5, 8'h81);
      send_word(OP_PIXEL, 8'hff, 8'h00, CHAN_W'(40 + 10 * row));
    end
    // pixel while draining, dropped
    send_word(OP_PIXEL, 8'hff, 8'hff, 8'hff);
    // width + 1 flushes, the last one ends the frame
    repeat (4) send_flush();

    // random geometry and content
    fed_words = 0;
    while (fed_words < RANDOM_WORDS) run_phase();

    // widest line: both registers above range clamp to 1024, the width to the full line store,
    // so the start of the frame stays in row 0 and owes no word
    calm = 1'b0;
    settle();
    write_reg(CFG_FRAME_WIDTH, 11'd2047);
    write_reg(CFG_FRAME_HEIGHT, 11'd2047);
    repeat (WIDE_PIXELS) send_pixel(1'b0);

    in_valid = 1'b0;
    while (tracker.owed_edges.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (tracker.mismatches == 0) begin
      $display("[prewitt_edge_rgb_3x3] OK");
    end else begin
      $display("[prewitt_edge_rgb_3x3] ERROR");
    end
    $finish;
  end

endmodule
